@@ sv/key_id_allocator_defines.svh @@
// assertion macros for the key allocator
`ifndef KEY_ID_ALLOCATOR_DEFINES_SVH
`define KEY_ID_ALLOCATOR_DEFINES_SVH

// same-cycle implication, checked outside reset
`define KIA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define KIA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/kia_pkg.sv @@
`timescale 1ns / 1ps

package kia_pkg;

  localparam int unsigned KEY_W          = 10;
  localparam int unsigned CMD_W          = 2;
  localparam int unsigned STS_W          = 2;
  localparam int unsigned KEY_SPACE_DEF  = 1024;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_MARK  = 2'd2,
    CMD_BUILD = 2'd3
  } cmd_e;

  typedef enum logic [STS_W-1:0] {
    STS_OK        = 2'd0,
    STS_EXHAUSTED = 2'd1,
    STS_FULL      = 2'd2,
    STS_RANGE     = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_ALLOC = 4'b0100,
    S_BUILD = 4'b1000
  } state_e;

endpackage

@@ sv/key_id_allocator.sv @@
// free, mark and counter allocate answer in the cycle after the word is taken; an allocate
// that pops the stack first reads the stack memory in S_ALLOC, and a build walks the mark
// memory one key a cycle up to largest, then answers; one word is in flight at a time
// reset: control clears at once, then a clearing pass over the whole mark memory during
// which no word is taken; the stack memory is never cleared
`timescale 1ns / 1ps

`include "key_id_allocator_defines.svh"

module key_id_allocator
  import kia_pkg::*;
#(
  parameter int unsigned KEY_SPACE = KEY_SPACE_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [CMD_W-1:0] command_i,
  input  logic [KEY_W-1:0] key_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [KEY_W-1:0] key_out_o,
  output logic [STS_W-1:0] status_o
);

  localparam int unsigned IW       = $clog2(KEY_SPACE);
  localparam int unsigned CW       = $clog2(KEY_SPACE + 1);
  localparam int unsigned KeyMax   = (1 << KEY_W) - 1;
  localparam int unsigned NextLim  = (KEY_SPACE - 1 < KeyMax) ? KEY_SPACE - 1 : KeyMax;
  localparam int unsigned KeyLim   = (KEY_SPACE < KeyMax + 1) ? KEY_SPACE : KeyMax + 1;
  localparam logic [KEY_W-1:0] NextMax   = KEY_W'(NextLim);
  localparam logic [CW-1:0]    CountFull = CW'(KEY_SPACE);
  localparam logic [IW-1:0]    LastIdx   = IW'(KEY_SPACE - 1);

  state_e           state_q, state_d;
  logic [CW-1:0]    count_q, count_d;
  logic [KEY_W-1:0] next_q, next_d;
  logic [KEY_W-1:0] largest_q, largest_d;
  logic [KEY_W-1:0] walk_q, walk_d;
  logic [KEY_W-1:0] pidx_q, pidx_d;
  logic             issue_q, issue_d;
  logic             pv_q, pv_d;
  logic             full_q, full_d;
  logic [IW-1:0]    clr_q, clr_d;
  logic             out_valid_q, out_valid_d;
  logic [KEY_W-1:0] key_out_q, key_out_d;
  status_e          status_q, status_d;

  logic [KEY_W-1:0] stack_mem [KEY_SPACE];
  logic             marks_mem [KEY_SPACE];

  logic             stk_we, stk_re;
  logic [IW-1:0]    stk_waddr, stk_raddr;
  logic [KEY_W-1:0] stk_wdata, stk_rdata_q;
  logic             mark_we, mark_wdata, mark_rdata_q;
  logic [IW-1:0]    mark_waddr, mark_raddr;

  logic             accept, key_ok, load;
  logic [KEY_W-1:0] load_key;
  status_e          load_sts;

  assign in_ready_o = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;
  assign key_ok     = (key_i != '0) && (32'(key_i) < KeyLim);

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    next_d     = next_q;
    largest_d  = largest_q;
    walk_d     = walk_q;
    pidx_d     = pidx_q;
    issue_d    = issue_q;
    pv_d       = pv_q;
    full_d     = full_q;
    clr_d      = clr_q;
    stk_we     = 1'b0;
    stk_re     = 1'b0;
    stk_waddr  = IW'(count_q);
    stk_raddr  = IW'(count_q - CW'(1));
    stk_wdata  = key_i;
    mark_we    = 1'b0;
    mark_wdata = 1'b0;
    mark_waddr = IW'(key_i);
    mark_raddr = IW'(walk_q);
    load       = 1'b0;
    load_key   = '0;
    load_sts   = STS_OK;

    case (state_q)
      S_CLEAR: begin
        mark_we    = 1'b1;
        mark_waddr = clr_q;
        clr_d      = clr_q + IW'(1);
        if (clr_q == LastIdx) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          case (cmd_e'(command_i))
            CMD_ALLOC: begin
              if (count_q != '0) begin
                stk_re  = 1'b1;
                count_d = count_q - CW'(1);
                state_d = S_ALLOC;
              end else if (next_q >= NextMax) begin
                load     = 1'b1;
                load_sts = STS_EXHAUSTED;
              end else begin
                next_d   = next_q + KEY_W'(1);
                load     = 1'b1;
                load_key = next_q + KEY_W'(1);
              end
            end
            CMD_FREE: begin
              load     = 1'b1;
              load_key = key_i;
              if (!key_ok) begin
                load_sts = STS_RANGE;
              end else if (count_q == CountFull) begin
                load_sts = STS_FULL;
              end else begin
                stk_we  = 1'b1;
                count_d = count_q + CW'(1);
              end
            end
            CMD_MARK: begin
              load     = 1'b1;
              load_key = key_i;
              if (!key_ok) begin
                load_sts = STS_RANGE;
              end else begin
                mark_we    = 1'b1;
                mark_wdata = 1'b1;
                if (key_i > largest_q) begin
                  largest_d = key_i;
                end
              end
            end
            CMD_BUILD: begin
              state_d = S_BUILD;
              walk_d  = KEY_W'(1);
              issue_d = (largest_q != '0);
              pv_d    = 1'b0;
              full_d  = 1'b0;
            end
            default: ;
          endcase
        end
      end
      S_ALLOC: begin
        load     = 1'b1;
        load_key = stk_rdata_q;
        state_d  = S_IDLE;
      end
      S_BUILD: begin
        // read mark of walk_q, act on the previous key's mark
        pv_d   = issue_q;
        pidx_d = walk_q;
        if (issue_q) begin
          walk_d = walk_q + KEY_W'(1);
          if (walk_q == largest_q) begin
            issue_d = 1'b0;
          end
        end
        if (pv_q) begin
          mark_we    = 1'b1;
          mark_waddr = IW'(pidx_q);
          if ((pidx_q < largest_q) && !mark_rdata_q) begin
            if (count_q == CountFull) begin
              full_d = 1'b1;
            end else begin
              stk_we    = 1'b1;
              stk_wdata = pidx_q;
              count_d   = count_q + CW'(1);
            end
          end
        end
        if (!issue_q && !pv_q) begin
          load      = 1'b1;
          load_sts  = full_q ? STS_FULL : STS_OK;
          next_d    = largest_q;
          largest_d = '0;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (load) begin
      out_valid_d = 1'b1;
      key_out_d   = load_key;
      status_d    = load_sts;
    end else begin
      out_valid_d = out_valid_q && !out_ready_i;
      key_out_d   = key_out_q;
      status_d    = status_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      count_q     <= '0;
      next_q      <= '0;
      largest_q   <= '0;
      issue_q     <= 1'b0;
      pv_q        <= 1'b0;
      full_q      <= 1'b0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      next_q      <= next_d;
      largest_q   <= largest_d;
      issue_q     <= issue_d;
      pv_q        <= pv_d;
      full_q      <= full_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    walk_q    <= walk_d;
    pidx_q    <= pidx_d;
    key_out_q <= key_out_d;
    status_q  <= status_d;
  end

  // free stack memory
  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stack_mem[stk_waddr] <= stk_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stk_re) begin
      stk_rdata_q <= stack_mem[stk_raddr];
    end
  end

  // used mark memory
  always_ff @(posedge clk_i) begin
    if (mark_we) begin
      marks_mem[mark_waddr] <= mark_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    mark_rdata_q <= marks_mem[mark_raddr];
  end

  assign out_valid_o = out_valid_q;
  assign key_out_o   = key_out_q;
  assign status_o    = status_q;

  `KIA_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CountFull, "stack count beyond key space")
  `KIA_ASSERT_NOW(a_next_bound, 1'b1, next_q <= NextMax, "next counter beyond limit")
  `KIA_ASSERT_NEXT(a_pop,
    accept && (command_i == CMD_ALLOC) && (count_q != '0),
    (state_q == S_ALLOC) && (count_q == $past(count_q) - CW'(1)),
    "stack pop did not enter read cycle")
  `KIA_ASSERT_NEXT(a_build_end,
    (state_q == S_BUILD) && !issue_q && !pv_q,
    (largest_q == '0) && out_valid_q && (state_q == S_IDLE),
    "build did not finish cleanly")

endmodule
